### hw/rtl/splh_pkg.sv
// splh_pkg: opcodes, status codes, register indexes, sequencer states and
// distance constants for the shortest path engine
// no dependencies
package splh_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic REG_NODE_COUNT  = 1'b0;
    localparam logic REG_SOURCE_NODE = 1'b1;

    localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;
    localparam logic [31:0] DIST_TOP = 32'hFFFF_FFFE;
    localparam logic [14:0] CNT_TOP  = 15'h7FFF;

    typedef enum logic [1:0] {
        SW_INIT,
        SW_RUN,
        SW_EDGES
    } sweep_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SWEEP,
        S_ADD_RD,
        S_ADD_WR,
        S_ADD_LINK,
        S_SRC,
        S_PU_START,
        S_PU_UP,
        S_PU_CMP,
        S_PU_END,
        S_ED_RD,
        S_ED_DST,
        S_ED_REL,
        S_POP_START,
        S_POP_TOP,
        S_POP_LAST,
        S_SD_C,
        S_SD_C1,
        S_SD_C2,
        S_SD_END,
        S_CK_RD,
        S_CK_EV,
        S_RD_WAIT,
        S_RD_EV,
        S_RESP
    } state_t;

endpackage

### hw/rtl/shortest_path_lazy_heap.sv
// shortest_path_lazy_heap: single-source shortest path engine, binary min-heap
// with lazy deletion, node, edge and heap state in simple dual-port memories
// depends on splh_pkg
//
// One item in, one result out. Edges are loaded with add items and kept per
// origin node in load order (linked lists in the edge memory); a run item
// computes distances from source_node and reports push, pop and skip counts
// on this and every later result; a read item returns one node's distance.
// Timing is set by the single read port of each memory: clear edges and run
// both start with a sweep over the node memories (one entry a cycle). A run
// then works through its pops, each sifted down the heap levels, the edges
// it visits, and its pushes, each moved up the heap levels. After reset the
// block sweeps the node memories before taking its first item; register
// writes are taken at any time. A finished result sits in an output register,
// so the next item is taken while the result still waits for its transfer.
module shortest_path_lazy_heap #(
    parameter int MAX_NODES        = 1024,
    parameter int MAX_EDGES        = 16384,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [9:0]  from_node,
    input  logic [9:0]  to_node,
    input  logic [16:0] weight,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [9:0]  node_index,
    output logic [31:0] distance,
    output logic        reached,
    output logic [14:0] run_pushes,
    output logic [14:0] run_pops,
    output logic [14:0] run_skips
);
    import splh_pkg::*;

    // widths that follow from the sizes
    localparam int NAW        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCW        = $clog2(MAX_NODES + 1);
    localparam int EAW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ELW        = $clog2(MAX_EDGES + 1);
    localparam int HEAP_DEPTH = MAX_EDGES + 1;
    localparam int HAW        = $clog2(HEAP_DEPTH);
    localparam int HSW        = $clog2(HEAP_DEPTH + 1);
    localparam int CIW        = HSW + 1;
    localparam int WW         = WEIGHT_FRAC_BITS + 1;
    localparam logic [31:0] W_ONE = 32'd1 << WEIGHT_FRAC_BITS;

    // heap entries order by distance, then by node
    typedef struct packed {
        logic [31:0]    d;
        logic [NAW-1:0] n;
    } hent_t;

    typedef struct packed {
        logic [NAW-1:0] to;
        logic [WW-1:0]  w;
    } edge_t;

    // memories
    logic [31:0]  dist_mem [MAX_NODES];
    logic [ELW-1:0] head_mem [MAX_NODES];
    logic [EAW-1:0] tail_mem [MAX_NODES];
    edge_t        edge_mem [MAX_EDGES];
    logic [ELW-1:0] next_mem [MAX_EDGES];
    hent_t        heap_mem [HEAP_DEPTH];

    logic           dist_we;
    logic [NAW-1:0] dist_waddr, dist_raddr;
    logic [31:0]    dist_wdata, dist_rd;
    logic           head_we;
    logic [NAW-1:0] head_waddr, head_raddr;
    logic [ELW-1:0] head_wdata, head_rd;
    logic           tail_we;
    logic [NAW-1:0] tail_waddr, tail_raddr;
    logic [EAW-1:0] tail_wdata, tail_rd;
    logic           edge_we;
    logic [EAW-1:0] edge_waddr, edge_raddr;
    edge_t          edge_wdata, edge_rd;
    logic           next_we;
    logic [EAW-1:0] next_waddr, next_raddr;
    logic [ELW-1:0] next_wdata, next_rd;
    logic           heap_we;
    logic [HAW-1:0] heap_waddr, heap_raddr;
    hent_t          heap_wdata, heap_rd;

    // control registers
    state_t         state_reg, state_next;
    sweep_t         sweep_kind_reg, sweep_kind_next;
    logic [NCW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [NCW-1:0] node_count_reg;
    logic [9:0]     source_node_reg;
    logic [ELW-1:0] edge_count_reg, edge_count_next;
    logic [HSW-1:0] heap_size_reg, heap_size_next;
    logic [14:0]    push_cnt_reg, push_cnt_next;
    logic [14:0]    pop_cnt_reg, pop_cnt_next;
    logic [14:0]    skip_cnt_reg, skip_cnt_next;
    logic           out_valid_reg, out_valid_next;

    // payload registers
    logic [9:0]     from_reg, from_next;
    logic [9:0]     to_reg, to_next;
    logic [16:0]    weight_reg, weight_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic [9:0]     res_nidx_reg, res_nidx_next;
    logic [31:0]    res_dist_reg, res_dist_next;
    logic           res_reached_reg, res_reached_next;
    logic [1:0]     status_reg, status_next;
    logic [9:0]     node_index_reg, node_index_next;
    logic [31:0]    distance_reg, distance_next;
    logic           reached_reg, reached_next;
    logic [14:0]    out_push_reg, out_push_next;
    logic [14:0]    out_pop_reg, out_pop_next;
    logic [14:0]    out_skip_reg, out_skip_next;
    hent_t          ent_reg, ent_next;
    hent_t          top_reg, top_next;
    hent_t          last_reg, last_next;
    hent_t          child_reg, child_next;
    logic [CIW-1:0] idx_reg, idx_next;
    logic [ELW-1:0] e_reg, e_next;
    logic [ELW-1:0] nxt_reg, nxt_next;
    logic [NAW-1:0] eto_reg, eto_next;
    logic [WW-1:0]  ew_reg, ew_next;
    logic [EAW-1:0] link_reg, link_next;

    // helpers
    logic           in_accept;
    logic           from_ok, to_ok, src_ok, eto_ok;
    logic           sweep_last, out_load;
    logic [EAW-1:0] k_addr;
    logic [WW-1:0]  w_sat;
    logic [32:0]    sum_w;
    logic [31:0]    new_dist;
    logic [CIW-1:0] c_idx, c1_idx, p_idx, size_ext;
    logic           second_ok;
    hent_t          cand;
    logic [CIW-1:0] cand_idx;
    logic [10:0]    nc_wr;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && (state_reg == S_IDLE);
    assign from_ok    = 32'(from_node) < 32'(node_count_reg);
    assign to_ok      = 32'(to_node) < 32'(node_count_reg);
    assign src_ok     = 32'(source_node_reg) < 32'(node_count_reg);
    assign eto_ok     = 32'(eto_reg) < 32'(node_count_reg);
    assign sweep_last = (sweep_cnt_reg == NCW'(MAX_NODES - 1));
    assign out_load   = !out_valid_reg || !out_stall;
    assign k_addr     = edge_count_reg[EAW-1:0];
    assign w_sat      = (32'(weight_reg) > W_ONE) ? W_ONE[WW-1:0] : WW'(weight_reg);

    // saturating relax sum
    assign sum_w    = {1'b0, top_reg.d} + 33'(ew_reg);
    assign new_dist = (sum_w >= 33'({1'b0, DIST_INF})) ? DIST_TOP : sum_w[31:0];

    // heap index arithmetic, idx_reg is the hole position
    assign size_ext  = CIW'(heap_size_reg);
    assign c_idx     = {idx_reg[CIW-2:0], 1'b1};
    assign c1_idx    = c_idx + CIW'(1);
    assign p_idx     = (idx_reg - CIW'(1)) >> 1;
    assign second_ok = (c1_idx < size_ext);
    assign cand      = (second_ok && (heap_rd < child_reg)) ? heap_rd : child_reg;
    assign cand_idx  = (second_ok && (heap_rd < child_reg)) ? c1_idx : c_idx;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign nc_wr  = pwdata[10:0];

    always_comb
    begin
        case (paddr[2])
            REG_NODE_COUNT:  prdata = 32'(node_count_reg);
            REG_SOURCE_NODE: prdata = 32'(source_node_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= NCW'(1);
            source_node_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_NODE_COUNT:
                begin
                    // zero reads as one, too large clamps to the node capacity
                    if (nc_wr == 11'd0)
                        node_count_reg <= NCW'(1);
                    else if (32'(nc_wr) > MAX_NODES)
                        node_count_reg <= NCW'(MAX_NODES);
                    else
                        node_count_reg <= NCW'(nc_wr);
                end
                REG_SOURCE_NODE: source_node_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // memories, one write and one registered read per cycle each
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_waddr] <= dist_wdata;
        dist_rd <= dist_mem[dist_raddr];
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        head_rd <= head_mem[head_raddr];
        if (tail_we)
            tail_mem[tail_waddr] <= tail_wdata;
        tail_rd <= tail_mem[tail_raddr];
        if (edge_we)
            edge_mem[edge_waddr] <= edge_wdata;
        edge_rd <= edge_mem[edge_raddr];
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        next_rd <= next_mem[next_raddr];
        if (heap_we)
            heap_mem[heap_waddr] <= heap_wdata;
        heap_rd <= heap_mem[heap_raddr];
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (opcode_t'(opcode))
                        OP_CLEAR: state_next = S_SWEEP;
                        OP_RUN:   state_next = S_SWEEP;
                        OP_ADD:
                        begin
                            if (!from_ok || !to_ok || (32'(edge_count_reg) >= MAX_EDGES))
                                state_next = S_RESP;
                            else
                                state_next = S_ADD_RD;
                        end
                        OP_READ:  state_next = from_ok ? S_RD_WAIT : S_RESP;
                        default:  state_next = S_RESP;
                    endcase
                end
            end
            S_SWEEP:
            begin
                if (sweep_last)
                begin
                    case (sweep_kind_reg)
                        SW_INIT:  state_next = S_IDLE;
                        SW_RUN:   state_next = src_ok ? S_SRC : S_RESP;
                        SW_EDGES: state_next = S_RESP;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD:    state_next = S_ADD_WR;
            S_ADD_WR:    state_next = (head_rd == '0) ? S_RESP : S_ADD_LINK;
            S_ADD_LINK:  state_next = S_RESP;
            S_SRC:       state_next = S_PU_START;
            S_PU_START:
                state_next = (32'(heap_size_reg) >= HEAP_DEPTH) ? S_ED_RD : S_PU_UP;
            S_PU_UP:     state_next = (idx_reg == '0) ? S_PU_END : S_PU_CMP;
            S_PU_CMP:    state_next = (ent_reg < heap_rd) ? S_PU_UP : S_PU_END;
            S_PU_END:    state_next = S_ED_RD;
            S_ED_RD:     state_next = (e_reg == '0) ? S_POP_START : S_ED_DST;
            S_ED_DST:    state_next = (32'(edge_rd.to) < 32'(node_count_reg)) ? S_ED_REL
                                                                               : S_ED_RD;
            S_ED_REL:    state_next = (new_dist < dist_rd) ? S_PU_START : S_ED_RD;
            S_POP_START: state_next = (heap_size_reg == '0) ? S_RESP : S_POP_TOP;
            S_POP_TOP:   state_next = S_POP_LAST;
            S_POP_LAST:  state_next = S_SD_C;
            S_SD_C:      state_next = (c_idx >= size_ext) ? S_SD_END : S_SD_C1;
            S_SD_C1:     state_next = S_SD_C2;
            S_SD_C2:     state_next = (cand < last_reg) ? S_SD_C : S_SD_END;
            S_SD_END:    state_next = S_CK_RD;
            S_CK_RD:     state_next = S_CK_EV;
            S_CK_EV:     state_next = (top_reg.d > dist_rd) ? S_POP_START : S_ED_RD;
            S_RD_WAIT:   state_next = S_RD_EV;
            S_RD_EV:     state_next = S_RESP;
            S_RESP:      state_next = out_load ? S_IDLE : S_RESP;
            default:     state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: memory controls and register updates
    // ------------------------------------------------------------------
    always_comb
    begin
        sweep_kind_next  = sweep_kind_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        edge_count_next  = edge_count_reg;
        heap_size_next   = heap_size_reg;
        push_cnt_next    = push_cnt_reg;
        pop_cnt_next     = pop_cnt_reg;
        skip_cnt_next    = skip_cnt_reg;
        out_valid_next   = out_valid_reg;
        from_next        = from_reg;
        to_next          = to_reg;
        weight_next      = weight_reg;
        res_status_next  = res_status_reg;
        res_nidx_next    = res_nidx_reg;
        res_dist_next    = res_dist_reg;
        res_reached_next = res_reached_reg;
        status_next      = status_reg;
        node_index_next  = node_index_reg;
        distance_next    = distance_reg;
        reached_next     = reached_reg;
        out_push_next    = out_push_reg;
        out_pop_next     = out_pop_reg;
        out_skip_next    = out_skip_reg;
        ent_next         = ent_reg;
        top_next         = top_reg;
        last_next        = last_reg;
        child_next       = child_reg;
        idx_next         = idx_reg;
        e_next           = e_reg;
        nxt_next         = nxt_reg;
        eto_next         = eto_reg;
        ew_next          = ew_reg;
        link_next        = link_reg;

        dist_we    = 1'b0;
        dist_waddr = '0;
        dist_wdata = DIST_INF;
        dist_raddr = '0;
        head_we    = 1'b0;
        head_waddr = '0;
        head_wdata = '0;
        head_raddr = '0;
        tail_we    = 1'b0;
        tail_waddr = '0;
        tail_wdata = '0;
        tail_raddr = '0;
        edge_we    = 1'b0;
        edge_waddr = '0;
        edge_wdata = '0;
        edge_raddr = '0;
        next_we    = 1'b0;
        next_waddr = '0;
        next_wdata = '0;
        next_raddr = '0;
        heap_we    = 1'b0;
        heap_waddr = '0;
        heap_wdata = '0;
        heap_raddr = '0;

        // result register drains on its transfer
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    from_next        = from_node;
                    to_next          = to_node;
                    weight_next      = weight;
                    res_status_next  = STAT_OK;
                    res_nidx_next    = '0;
                    res_dist_next    = '0;
                    res_reached_next = 1'b0;
                    case (opcode_t'(opcode))
                        OP_CLEAR:
                        begin
                            sweep_kind_next = SW_EDGES;
                            sweep_cnt_next  = '0;
                            edge_count_next = '0;
                        end
                        OP_ADD:
                        begin
                            if (!from_ok || !to_ok)
                                res_status_next = STAT_RANGE;
                            else if (32'(edge_count_reg) >= MAX_EDGES)
                                res_status_next = STAT_FULL;
                        end
                        OP_RUN:
                        begin
                            sweep_kind_next = SW_RUN;
                            sweep_cnt_next  = '0;
                            heap_size_next  = '0;
                            push_cnt_next   = '0;
                            pop_cnt_next    = '0;
                            skip_cnt_next   = '0;
                        end
                        OP_READ:
                        begin
                            res_nidx_next = from_node;
                            if (!from_ok)
                            begin
                                res_status_next = STAT_RANGE;
                                res_dist_next   = DIST_INF;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SWEEP:
            begin
                // node memories back to unreachable / empty, one entry a cycle
                dist_we    = (sweep_kind_reg != SW_EDGES);
                dist_waddr = sweep_cnt_reg[NAW-1:0];
                dist_wdata = DIST_INF;
                head_we    = (sweep_kind_reg != SW_RUN);
                head_waddr = sweep_cnt_reg[NAW-1:0];
                head_wdata = '0;
                sweep_cnt_next = sweep_cnt_reg + NCW'(1);
                if (sweep_last && (sweep_kind_reg == SW_RUN) && !src_ok)
                    res_status_next = STAT_RANGE;
            end
            S_ADD_RD:
            begin
                head_raddr = NAW'(from_reg);
                tail_raddr = NAW'(from_reg);
            end
            S_ADD_WR:
            begin
                edge_we       = 1'b1;
                edge_waddr    = k_addr;
                edge_wdata.to = NAW'(to_reg);
                edge_wdata.w  = w_sat;
                next_we       = 1'b1;
                next_waddr    = k_addr;
                next_wdata    = '0;
                tail_we       = 1'b1;
                tail_waddr    = NAW'(from_reg);
                tail_wdata    = k_addr;
                if (head_rd == '0)
                begin
                    head_we    = 1'b1;
                    head_waddr = NAW'(from_reg);
                    head_wdata = edge_count_reg + ELW'(1);
                end
                link_next       = tail_rd;
                edge_count_next = edge_count_reg + ELW'(1);
            end
            S_ADD_LINK:
            begin
                // append behind the old tail, link is index plus one
                next_we    = 1'b1;
                next_waddr = link_reg;
                next_wdata = edge_count_reg;
            end
            S_SRC:
            begin
                dist_we    = 1'b1;
                dist_waddr = NAW'(source_node_reg);
                dist_wdata = '0;
                ent_next.d = '0;
                ent_next.n = NAW'(source_node_reg);
                nxt_next   = '0;
            end
            S_PU_START:
            begin
                if (32'(heap_size_reg) >= HEAP_DEPTH)
                    e_next = nxt_reg;
                else
                begin
                    idx_next       = size_ext;
                    heap_size_next = heap_size_reg + HSW'(1);
                end
            end
            S_PU_UP:
            begin
                heap_raddr = p_idx[HAW-1:0];
            end
            S_PU_CMP:
            begin
                if (ent_reg < heap_rd)
                begin
                    heap_we    = 1'b1;
                    heap_waddr = idx_reg[HAW-1:0];
                    heap_wdata = heap_rd;
                    idx_next   = p_idx;
                end
            end
            S_PU_END:
            begin
                heap_we    = 1'b1;
                heap_waddr = idx_reg[HAW-1:0];
                heap_wdata = ent_reg;
                if (push_cnt_reg != CNT_TOP)
                    push_cnt_next = push_cnt_reg + 15'd1;
                e_next = nxt_reg;
            end
            S_ED_RD:
            begin
                edge_raddr = EAW'(e_reg - ELW'(1));
                next_raddr = EAW'(e_reg - ELW'(1));
            end
            S_ED_DST:
            begin
                eto_next   = edge_rd.to;
                ew_next    = edge_rd.w;
                nxt_next   = next_rd;
                dist_raddr = edge_rd.to;
                // edges to nodes beyond the current node count are passed over
                if (32'(edge_rd.to) >= 32'(node_count_reg))
                    e_next = next_rd;
            end
            S_ED_REL:
            begin
                if (new_dist < dist_rd)
                begin
                    dist_we    = 1'b1;
                    dist_waddr = eto_reg;
                    dist_wdata = new_dist;
                    ent_next.d = new_dist;
                    ent_next.n = eto_reg;
                end
                else
                    e_next = nxt_reg;
            end
            S_POP_START:
            begin
                heap_raddr = '0;
            end
            S_POP_TOP:
            begin
                top_next       = heap_rd;
                heap_size_next = heap_size_reg - HSW'(1);
                heap_raddr     = HAW'(heap_size_reg - HSW'(1));
            end
            S_POP_LAST:
            begin
                last_next = heap_rd;
                idx_next  = '0;
            end
            S_SD_C:
            begin
                heap_raddr = c_idx[HAW-1:0];
            end
            S_SD_C1:
            begin
                child_next = heap_rd;
                heap_raddr = c1_idx[HAW-1:0];
            end
            S_SD_C2:
            begin
                if (cand < last_reg)
                begin
                    heap_we    = 1'b1;
                    heap_waddr = idx_reg[HAW-1:0];
                    heap_wdata = cand;
                    idx_next   = cand_idx;
                end
            end
            S_SD_END:
            begin
                heap_we    = 1'b1;
                heap_waddr = idx_reg[HAW-1:0];
                heap_wdata = last_reg;
                if (pop_cnt_reg != CNT_TOP)
                    pop_cnt_next = pop_cnt_reg + 15'd1;
            end
            S_CK_RD:
            begin
                dist_raddr = top_reg.n;
                head_raddr = top_reg.n;
            end
            S_CK_EV:
            begin
                // stale entry: a shorter distance was settled after its push
                if (top_reg.d > dist_rd)
                begin
                    if (skip_cnt_reg != CNT_TOP)
                        skip_cnt_next = skip_cnt_reg + 15'd1;
                end
                else
                    e_next = head_rd;
            end
            S_RD_WAIT:
            begin
                dist_raddr = NAW'(from_reg);
            end
            S_RD_EV:
            begin
                res_dist_next    = dist_rd;
                res_reached_next = (dist_rd != DIST_INF);
            end
            S_RESP:
            begin
                // counters are captured so a waiting result holds still
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    node_index_next = res_nidx_reg;
                    distance_next   = res_dist_reg;
                    reached_next    = res_reached_reg;
                    out_push_next   = push_cnt_reg;
                    out_pop_next    = pop_cnt_reg;
                    out_skip_next   = skip_cnt_reg;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_kind_reg <= SW_INIT;
            sweep_cnt_reg  <= '0;
            edge_count_reg <= '0;
            heap_size_reg  <= '0;
            push_cnt_reg   <= '0;
            pop_cnt_reg    <= '0;
            skip_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_kind_reg <= sweep_kind_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            edge_count_reg <= edge_count_next;
            heap_size_reg  <= heap_size_next;
            push_cnt_reg   <= push_cnt_next;
            pop_cnt_reg    <= pop_cnt_next;
            skip_cnt_reg   <= skip_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        from_reg        <= from_next;
        to_reg          <= to_next;
        weight_reg      <= weight_next;
        res_status_reg  <= res_status_next;
        res_nidx_reg    <= res_nidx_next;
        res_dist_reg    <= res_dist_next;
        res_reached_reg <= res_reached_next;
        status_reg      <= status_next;
        node_index_reg  <= node_index_next;
        distance_reg    <= distance_next;
        reached_reg     <= reached_next;
        out_push_reg    <= out_push_next;
        out_pop_reg     <= out_pop_next;
        out_skip_reg    <= out_skip_next;
        ent_reg         <= ent_next;
        top_reg         <= top_next;
        last_reg        <= last_next;
        child_reg       <= child_next;
        idx_reg         <= idx_next;
        e_reg           <= e_next;
        nxt_reg         <= nxt_next;
        eto_reg         <= eto_next;
        ew_reg          <= ew_next;
        link_reg        <= link_next;
    end

    // result outputs
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign node_index = node_index_reg;
    assign distance   = distance_reg;
    assign reached    = reached_reg;
    assign run_pushes = out_push_reg;
    assign run_pops   = out_pop_reg;
    assign run_skips  = out_skip_reg;

`ifndef NO_ASSERTIONS
    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(heap_size_reg) <= HEAP_DEPTH)
        else $error("heap size beyond heap depth");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edge_count_reg) <= MAX_EDGES)
        else $error("edge count beyond edge capacity");

    a_item_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != S_IDLE)
        else $error("accepted item left the sequencer idle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP_TOP |-> $past(heap_size_reg) != '0)
        else $error("pop from an empty heap");
`endif

endmodule

### test/shortest_path_lazy_heap_check.sv
// shortest_path_lazy_heap_check: watches the config port and both channels,
// predicts every result of the shortest path engine and compares field by field
// depends on splh_pkg
module shortest_path_lazy_heap_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [9:0]  from_node,
    input  logic [9:0]  to_node,
    input  logic [16:0] weight,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [9:0]  node_index,
    input  logic [31:0] distance,
    input  logic        reached,
    input  logic [14:0] run_pushes,
    input  logic [14:0] run_pops,
    input  logic [14:0] run_skips,
    output int          errors,
    output int          pending
);
    import splh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES    = 1024;
    localparam int EDGES    = 16384;
    localparam int HEAP_CAP = EDGES + 1;
    localparam logic [16:0] ONE = 17'h10000;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  node_index;
        logic [31:0] distance;
        logic        reached;
        logic [14:0] pushes;
        logic [14:0] pops;
        logic [14:0] skips;
    } path_result_t;

    path_result_t awaited_results[$];

    // engine state mirror
    logic [31:0] node_dist [NODES];
    logic [14:0] list_first[NODES];
    logic [13:0] list_last [NODES];
    logic [9:0]  edge_dest [EDGES];
    logic [16:0] edge_wt   [EDGES];
    logic [14:0] edge_link [EDGES];
    logic [31:0] heap_dist [HEAP_CAP];
    logic [9:0]  heap_node [HEAP_CAP];
    int          heap_len;
    int          edges_loaded;
    int          nodes_used;
    logic [9:0]  start_node;
    logic [14:0] pushes, pops, skips;

    function automatic bit entry_below(logic [31:0] da, logic [9:0] na,
                                       logic [31:0] db, logic [9:0] nb);
        return (da < db) || (da == db && na < nb);
    endfunction

    function automatic void heap_insert(logic [31:0] d, logic [9:0] n);
        int i;
        int p;
        if (heap_len >= HEAP_CAP) return;
        i = heap_len;
        heap_len++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!entry_below(d, n, heap_dist[p], heap_node[p])) break;
            heap_dist[i] = heap_dist[p];
            heap_node[i] = heap_node[p];
            i = p;
        end
        heap_dist[i] = d;
        heap_node[i] = n;
        if (pushes < CNT_TOP) pushes++;
    endfunction

    function automatic void heap_take(output logic [31:0] d, output logic [9:0] n);
        logic [31:0] last_d;
        logic [9:0]  last_n;
        int i;
        int c;
        d = heap_dist[0];
        n = heap_node[0];
        heap_len--;
        last_d = heap_dist[heap_len];
        last_n = heap_node[heap_len];
        i = 0;
        forever begin
            c = 2 * i + 1;
            if (c >= heap_len) break;
            if (c + 1 < heap_len &&
                entry_below(heap_dist[c+1], heap_node[c+1], heap_dist[c], heap_node[c]))
                c++;
            if (!entry_below(heap_dist[c], heap_node[c], last_d, last_n)) break;
            heap_dist[i] = heap_dist[c];
            heap_node[i] = heap_node[c];
            i = c;
        end
        heap_dist[i] = last_d;
        heap_node[i] = last_n;
        if (pops < CNT_TOP) pops++;
    endfunction

    function automatic void solve_paths();
        logic [31:0] d;
        logic [31:0] nd;
        logic [9:0]  n;
        int e;
        int v;
        foreach (node_dist[i]) node_dist[i] = DIST_INF;
        heap_len = 0;
        node_dist[start_node] = '0;
        heap_insert('0, start_node);
        while (heap_len > 0) begin
            heap_take(d, n);
            // lazy deletion: an entry beaten since its push is stale
            if (d > node_dist[n]) begin
                if (skips < CNT_TOP) skips++;
                continue;
            end
            e = list_first[n];
            while (e != 0 && e <= EDGES) begin
                v = edge_dest[e-1];
                if (v < nodes_used) begin
                    nd = (d > DIST_TOP - edge_wt[e-1]) ? DIST_TOP : d + edge_wt[e-1];
                    if (nd < node_dist[v]) begin
                        node_dist[v] = nd;
                        heap_insert(nd, v[9:0]);
                    end
                end
                e = edge_link[e-1];
            end
        end
    endfunction

    function automatic path_result_t predict_item(logic [1:0] op, logic [9:0] f,
                                                  logic [9:0] t, logic [16:0] w);
        path_result_t r;
        int k;
        r = '0;
        case (opcode_t'(op))
            OP_CLEAR: begin
                foreach (list_first[i]) list_first[i] = '0;
                edges_loaded = 0;
            end
            OP_ADD: begin
                if (f >= nodes_used || t >= nodes_used) r.status = STAT_RANGE;
                else if (edges_loaded >= EDGES) r.status = STAT_FULL;
                else begin
                    k = edges_loaded;
                    edges_loaded++;
                    edge_dest[k] = t;
                    edge_wt[k]   = (w > ONE) ? ONE : w;
                    edge_link[k] = '0;
                    if (list_first[f] == 0) list_first[f] = 15'(k + 1);
                    else edge_link[list_last[f]] = 15'(k + 1);
                    list_last[f] = 14'(k);
                end
            end
            OP_RUN: begin
                pushes = '0;
                pops   = '0;
                skips  = '0;
                if (start_node >= nodes_used) begin
                    foreach (node_dist[i]) node_dist[i] = DIST_INF;
                    r.status = STAT_RANGE;
                end else solve_paths();
            end
            default: begin
                r.node_index = f;
                if (f >= nodes_used) begin
                    r.status   = STAT_RANGE;
                    r.distance = DIST_INF;
                end else begin
                    r.distance = node_dist[f];
                    r.reached  = (node_dist[f] != DIST_INF);
                end
            end
        endcase
        r.pushes = pushes;
        r.pops   = pops;
        r.skips  = skips;
        return r;
    endfunction

    initial begin
        foreach (node_dist[i]) node_dist[i] = DIST_INF;
        foreach (list_first[i]) list_first[i] = '0;
        heap_len     = 0;
        edges_loaded = 0;
        nodes_used   = 1;
        start_node   = '0;
        pushes       = '0;
        pops         = '0;
        skips        = '0;
        errors       = 0;
        pending      = 0;
    end

    always @(posedge clk) begin
        path_result_t want;
        int v;
        if (rst_n) begin
            // register write lands on the access phase
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_NODE_COUNT) begin
                    v = pwdata[10:0];
                    nodes_used = (v < 1) ? 1 : (v > NODES) ? NODES : v;
                end else start_node = pwdata[9:0];
            end
            if (out_valid && !out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, status);
                        errors++;
                    end
                    if (node_index !== want.node_index) begin
                        $error("node_index exp %0d got %0d", want.node_index, node_index);
                        errors++;
                    end
                    if (distance !== want.distance) begin
                        $error("distance exp %0h got %0h", want.distance, distance);
                        errors++;
                    end
                    if (reached !== want.reached) begin
                        $error("reached exp %0d got %0d", want.reached, reached);
                        errors++;
                    end
                    if (run_pushes !== want.pushes) begin
                        $error("run_pushes exp %0d got %0d", want.pushes, run_pushes);
                        errors++;
                    end
                    if (run_pops !== want.pops) begin
                        $error("run_pops exp %0d got %0d", want.pops, run_pops);
                        errors++;
                    end
                    if (run_skips !== want.skips) begin
                        $error("run_skips exp %0d got %0d", want.skips, run_skips);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                awaited_results.insert(awaited_results.size(),
                                       predict_item(opcode, from_node, to_node, weight));
            pending = awaited_results.size();
        end
    end

endmodule

### test/shortest_path_lazy_heap_test.sv
// shortest_path_lazy_heap_test: top of the shortest path engine testbench,
// drives items, register writes and result stalls and gives the verdict
// depends on splh_pkg, shortest_path_lazy_heap and shortest_path_lazy_heap_check
module shortest_path_lazy_heap_test;
    import splh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [9:0]  from_node = '0;
    logic [9:0]  to_node = '0;
    logic [16:0] weight = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [9:0]  node_index;
    logic [31:0] distance;
    logic        reached;
    logic [14:0] run_pushes;
    logic [14:0] run_pops;
    logic [14:0] run_skips;

    int errors;
    int pending;

    // shaping of the random traffic
    bit calm = 1'b0;        // no idling on either side
    bit hold_req = 1'b0;    // receiver blocks for a long stretch once
    int nodes_now = 1;      // node count as the block sees it

    always #5 clk = ~clk;

    shortest_path_lazy_heap DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .from_node(from_node), .to_node(to_node), .weight(weight),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .node_index(node_index), .distance(distance),
        .reached(reached), .run_pushes(run_pushes), .run_pops(run_pops),
        .run_skips(run_skips)
    );

    shortest_path_lazy_heap_check CHECK (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .from_node(from_node), .to_node(to_node), .weight(weight),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .node_index(node_index), .distance(distance),
        .reached(reached), .run_pushes(run_pushes), .run_pops(run_pops),
        .run_skips(run_skips),
        .errors(errors), .pending(pending)
    );

    // one item transfer, with an occasional gap in front of it
    task automatic send_item(opcode_t op, int f, int t, int w);
        int gap;
        if (!calm && $urandom_range(99) < 14) begin
            gap = $urandom_range(4, 1);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        opcode    = op;
        from_node = f[9:0];
        to_node   = t[9:0];
        weight    = w[16:0];
        in_valid  = 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // register write, only once the block has drained every result
    task automatic set_reg(logic idx, int value);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_NODE_COUNT) begin
            value = value & 32'h7FF;
            nodes_now = (value < 1) ? 1 : (value > 1024) ? 1024 : value;
        end
    endtask

    // mostly in range, clustered on low nodes so that paths form
    function automatic int pick_node();
        if ($urandom_range(99) < 8) return $urandom_range(1023);
        if (nodes_now > 32 && $urandom_range(99) < 70) return $urandom_range(31);
        return $urandom_range(nodes_now - 1);
    endfunction

    // weights: small ones, the full range, and past 1.0 for saturation
    function automatic int pick_weight();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 20) return 65536;
        if (r < 40) return $urandom_range(131071);
        return $urandom_range(4096);
    endfunction

    // receiver side: random stalls, one long hold-off to back the block up
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !held) begin
                out_stall = 1'b1;
                repeat (2000) @(negedge clk);
                held = 1'b1;
            end
            out_stall = (!calm && $urandom_range(99) < 14);
        end
    end

    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int nc;
        int r;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed: default single node, before any run
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_READ, 5, 0, 0);
        send_item(OP_ADD, 0, 0, 5);
        send_item(OP_ADD, 0, 1, 5);
        send_item(OP_RUN, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        // node count of zero is taken as one
        set_reg(REG_NODE_COUNT, 0);
        set_reg(REG_SOURCE_NODE, 0);
        send_item(OP_READ, 1, 0, 0);
        // node count above the maximum clamps, source at the top node
        set_reg(REG_NODE_COUNT, 2047);
        set_reg(REG_SOURCE_NODE, 1023);
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_ADD, 1023, 0, 131071);
        send_item(OP_ADD, 0, 1023, 0);
        send_item(OP_ADD, 0, 512, 65536);
        send_item(OP_ADD, 512, 1023, 0);
        send_item(OP_ADD, 1023, 1023, 1);
        send_item(OP_RUN, 0, 0, 0);
        send_item(OP_READ, 1023, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_READ, 512, 0, 0);
        send_item(OP_READ, 1, 0, 0);
        // lowered node count: edges to nodes beyond it are ignored
        set_reg(REG_NODE_COUNT, 600);
        set_reg(REG_SOURCE_NODE, 0);
        send_item(OP_RUN, 0, 0, 0);
        send_item(OP_READ, 512, 0, 0);
        send_item(OP_READ, 700, 0, 0);
        // source out of range wipes the distances
        set_reg(REG_SOURCE_NODE, 700);
        send_item(OP_RUN, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        // clear keeps distances and counters
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_READ, 512, 0, 0);

        // random phases, each with its own graph size and source
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: nc = 1024;
                1: nc = 1;
                2: nc = $urandom_range(64, 2);
                3: nc = 2047;
                4: nc = $urandom_range(1023, 65);
                default: nc = $urandom_range(48, 2);
            endcase
            set_reg(REG_NODE_COUNT, nc);
            set_reg(REG_SOURCE_NODE, ($urandom_range(99) < 85) ?
                    $urandom_range(nodes_now - 1) : $urandom_range(1023));
            calm = (ph == 2);
            send_item(OP_CLEAR, 0, 0, 0);
            for (int k = 0; k < 210; k++) begin
                if (ph == 0 && k == 100) hold_req = 1'b1;
                r = $urandom_range(99);
                if (r < 2) send_item(OP_CLEAR, 0, 0, 0);
                else if (r < 52)
                    send_item(OP_ADD, pick_node(), pick_node(), pick_weight());
                else if (r < 58) send_item(OP_RUN, 0, 0, 0);
                else send_item(OP_READ, pick_node(), 0, 0);
            end
            calm = 1'b0;
        end

        // dense tiny graph with many parallel edges
        set_reg(REG_NODE_COUNT, 4);
        set_reg(REG_SOURCE_NODE, 0);
        send_item(OP_CLEAR, 0, 0, 0);
        for (int k = 0; k < 16; k++)
            send_item(OP_ADD, $urandom_range(3), $urandom_range(3), $urandom_range(131071));
        send_item(OP_RUN, 0, 0, 0);
        for (int n = 0; n < 5; n++) send_item(OP_READ, n, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_ADD, 1, 2, 100);
        send_item(OP_RUN, 0, 0, 0);
        send_item(OP_READ, 2, 0, 0);

        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hw/rtl/splh_pkg.sv
hw/rtl/shortest_path_lazy_heap.sv
test/shortest_path_lazy_heap_check.sv
test/shortest_path_lazy_heap_test.sv
